FILE: hdl/quoted_token_scanner_core_defines.svh
// Assertion macros for the quoted token scanner RTL, used by qts_fifo.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef QUOTED_TOKEN_SCANNER_CORE_DEFINES_SVH
`define QUOTED_TOKEN_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define QTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define QTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/qts_pkg.sv
// Shared types, character codes and byte classifier for the quoted token scanner.
// No dependencies.
package qts_pkg;

  // Token length counter width
  localparam int LEN_W = 16;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Character codes
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // Scanner modes
  typedef enum logic [1:0] {
    MODE_TOKEN = 2'd0,
    MODE_QUOTE = 2'd1,
    MODE_QEND  = 2'd2,
    MODE_TAIL  = 2'd3
  } mode_t;

  // Byte classes
  typedef enum logic [1:0] {
    CL_NORMAL = 2'd0,
    CL_QUOTE  = 2'd1,
    CL_SPACER = 2'd2,
    CL_DELIM  = 2'd3
  } class_t;

  // Queue entry kinds
  typedef enum logic [1:0] {
    K_BYTE = 2'd0,
    K_END  = 2'd1,
    K_CRLF = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tok_byte;
    logic [15:0] tok_len;
    logic [7:0]  term;
  } entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic class_t classify(input logic [7:0] b);
    class_t c;
    c = CL_NORMAL;
    if (b == CH_SQUOTE || b == CH_DQUOTE) begin
      c = CL_QUOTE;
    end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
      c = CL_SPACER;
    end else if (b == CH_LT || b == CH_GT || b == CH_NUL || b == CH_COLON ||
                 b == CH_SEMI || b == CH_COMMA || b == CH_EQUAL ||
                 b == CH_LBRACE || b == CH_RBRACE || b == CH_LPAREN ||
                 b == CH_RPAREN || b == CH_LBRACK || b == CH_RBRACK) begin
      c = CL_DELIM;
    end
    return c;
  endfunction

endpackage

FILE: hdl/qts_front.sv
// Front end: accepts input words, classifies bytes, tracks scan mode and
// token length, and pushes result commands into the queue. Uses qts_pkg.
module qts_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_text_byte,
  input  logic                    in_end_of_input,
  input  qts_pkg::fifo_stat_t     fifo_stat,
  output logic                    push,
  output qts_pkg::entry_t         push_entry
);

  qts_pkg::mode_t              mode_r, mode_nxt;
  logic                        dq_r, dq_nxt;
  logic [qts_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [qts_pkg::LEN_W-1:0]   len_inc1, len_inc2;
  logic [7:0]                  q_char;
  qts_pkg::class_t             cls;
  logic                        accept;
  logic                        emit;
  logic                        do_tok;
  qts_pkg::entry_t             ent;

  assign in_stall = fifo_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && emit;
  assign push_entry = ent;

  assign q_char = dq_r ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE;
  assign cls    = qts_pkg::classify(in_text_byte);

  // Saturating length increments
  assign len_inc1 = (len_r == qts_pkg::LEN_MAX) ? len_r : len_r + 1'b1;
  assign len_inc2 = (len_r >= qts_pkg::LEN_MAX - 1'b1) ? qts_pkg::LEN_MAX
                                                        : len_r + 2'd2;

  // Mode update and result command
  always_comb begin
    mode_nxt     = mode_r;
    dq_nxt       = dq_r;
    len_nxt      = len_r;
    emit         = 1'b0;
    do_tok       = 1'b0;
    ent.kind     = qts_pkg::K_BYTE;
    ent.tok_byte = in_text_byte;
    ent.tok_len  = '0;
    ent.term     = '0;

    if (in_end_of_input) begin
      // close a pending token with terminator zero
      if (mode_r != qts_pkg::MODE_TAIL && len_r != '0) begin
        emit         = 1'b1;
        ent.kind     = qts_pkg::K_END;
        ent.tok_byte = '0;
        ent.tok_len  = 16'(len_r);
      end
      mode_nxt = qts_pkg::MODE_TOKEN;
      len_nxt  = '0;
    end else begin
      unique case (mode_r)
        qts_pkg::MODE_QUOTE: begin
          if (in_text_byte == q_char) begin
            mode_nxt = qts_pkg::MODE_QEND;
          end else if (in_text_byte == qts_pkg::CH_CR) begin
            // CR dropped inside quotes
            emit = 1'b0;
          end else if (in_text_byte == qts_pkg::CH_LF) begin
            emit     = 1'b1;
            ent.kind = qts_pkg::K_CRLF;
            len_nxt  = len_inc2;
          end else begin
            emit    = 1'b1;
            len_nxt = len_inc1;
          end
        end
        qts_pkg::MODE_QEND: begin
          if (in_text_byte == q_char) begin
            // doubled quote stands for one quote
            emit     = 1'b1;
            len_nxt  = len_inc1;
            mode_nxt = qts_pkg::MODE_QUOTE;
          end else begin
            do_tok = 1'b1;
          end
        end
        qts_pkg::MODE_TAIL: begin
          // skip spacers, swallow one delimiter
          if (cls == qts_pkg::CL_DELIM) begin
            mode_nxt = qts_pkg::MODE_TOKEN;
          end else if (cls != qts_pkg::CL_SPACER) begin
            do_tok = 1'b1;
          end
        end
        qts_pkg::MODE_TOKEN: begin
          do_tok = 1'b1;
        end
      endcase
    end

    // Token-mode handling of one byte
    if (do_tok) begin
      mode_nxt = qts_pkg::MODE_TOKEN;
      case (cls)
        qts_pkg::CL_QUOTE: begin
          dq_nxt   = (in_text_byte == qts_pkg::CH_DQUOTE);
          mode_nxt = qts_pkg::MODE_QUOTE;
        end
        qts_pkg::CL_SPACER: begin
          if (len_r != '0) begin
            emit         = 1'b1;
            ent.kind     = qts_pkg::K_END;
            ent.tok_byte = '0;
            ent.tok_len  = 16'(len_r);
            ent.term     = in_text_byte;
            len_nxt      = '0;
            mode_nxt     = qts_pkg::MODE_TAIL;
          end
        end
        qts_pkg::CL_DELIM: begin
          emit         = 1'b1;
          ent.kind     = qts_pkg::K_END;
          ent.tok_byte = '0;
          ent.tok_len  = 16'(len_r);
          ent.term     = in_text_byte;
          len_nxt      = '0;
        end
        default: begin
          emit    = 1'b1;
          len_nxt = len_inc1;
        end
      endcase
    end
  end

  // State registers, updated per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= qts_pkg::MODE_TOKEN;
      dq_r   <= 1'b0;
      len_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      dq_r   <= dq_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

FILE: hdl/qts_fifo.sv
// Short command queue between scanner front and output back end.
// Uses qts_pkg and the assertion macros header.
`include "quoted_token_scanner_core_defines.svh"
module qts_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qts_pkg::entry_t     push_entry,
  input  logic                pop,
  output qts_pkg::entry_t     pop_entry,
  output qts_pkg::fifo_stat_t stat
);

  qts_pkg::entry_t                 mem [qts_pkg::FIFO_DEPTH];
  logic [qts_pkg::FIFO_AW-1:0]     wr_ptr_r;
  logic [qts_pkg::FIFO_AW-1:0]     rd_ptr_r;
  logic [qts_pkg::FIFO_AW:0]       count_r;

  assign stat.full  = (count_r == (qts_pkg::FIFO_AW+1)'(qts_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);

  // Storage write and first-word read
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry = mem[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `QTS_ASSERT_NOW(a_no_push_full, push, !stat.full, "push into full queue")
  `QTS_ASSERT_NOW(a_no_pop_empty, pop, !stat.empty, "pop from empty queue")
  `QTS_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1,
                   "fill count did not follow push")
  `QTS_ASSERT_NOW(a_count_bound, 1'b1,
                  count_r <= (qts_pkg::FIFO_AW+1)'(qts_pkg::FIFO_DEPTH),
                  "fill count beyond depth")

endmodule

FILE: hdl/qts_back.sv
// Back end: pops queue commands and drives the registered output word,
// splitting a CR LF command into two words. Uses qts_pkg.
module qts_back (
  input  logic                clk,
  input  logic                rst_n,
  input  qts_pkg::fifo_stat_t fifo_stat,
  input  qts_pkg::entry_t     pop_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_token_byte,
  output logic                out_token_end,
  output logic [15:0]         out_token_length,
  output logic [7:0]          out_terminator
);

  logic        valid_r;
  logic        pair_r;
  logic [7:0]  byte_r;
  logic        end_r;
  logic [15:0] len_r;
  logic [7:0]  term_r;
  logic        load;

  // Output register free or being taken this cycle
  assign load = !valid_r || !out_stall;
  assign pop  = load && !pair_r && !fifo_stat.empty;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pair_r  <= 1'b0;
    end else if (load) begin
      if (pair_r) begin
        valid_r <= 1'b1;
        pair_r  <= 1'b0;
      end else if (!fifo_stat.empty) begin
        valid_r <= 1'b1;
        pair_r  <= (pop_entry.kind == qts_pkg::K_CRLF);
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  // Payload: second half of CR LF, or a fresh command
  always_ff @(posedge clk) begin
    if (load && pair_r) begin
      byte_r <= qts_pkg::CH_LF;
      end_r  <= 1'b0;
      len_r  <= '0;
      term_r <= '0;
    end else if (pop) begin
      byte_r <= (pop_entry.kind == qts_pkg::K_CRLF) ? qts_pkg::CH_CR
                                                    : pop_entry.tok_byte;
      end_r  <= (pop_entry.kind == qts_pkg::K_END);
      len_r  <= pop_entry.tok_len;
      term_r <= pop_entry.term;
    end
  end

  assign out_valid        = valid_r;
  assign out_token_byte   = byte_r;
  assign out_token_end    = end_r;
  assign out_token_length = len_r;
  assign out_terminator   = term_r;

endmodule

FILE: hdl/quoted_token_scanner_core.sv
// Quoted token scanner top level: front end, command queue and output back end.
// Uses qts_pkg, qts_front, qts_fifo and qts_back.
//
// Usage: text arrives one byte per word on the in_ channel (in_text_byte,
// in_end_of_input); tokens leave as words on the out_ channel, one word per
// token byte and one end word (out_token_end = 1) carrying the token length
// and the terminating byte (0 at end of input). Both channels handshake with
// valid/stall; a word moves on a clock edge with valid high and stall low.
// Throughput: one input word per cycle while the queue is not full. Each
// byte costs one queue slot at most; an LF inside quotes expands to CR LF,
// which the back end sends as two output words, so a run of those slows
// input once the 4-entry queue fills.
// A result word is written into the queue at the edge that accepts its input
// word and is then loaded into the output register when that register is free
// or being taken.
// When the receiver stalls, the output word holds, the queue fills, and
// in_stall rises once the queue is full. Reset (rst_n low, synchronous)
// empties the queue, drops the output word and returns the scanner to token
// mode with zero length.
module quoted_token_scanner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_token_byte,
  output logic        out_token_end,
  output logic [15:0] out_token_length,
  output logic [7:0]  out_terminator
);

  qts_pkg::fifo_stat_t fifo_stat;
  qts_pkg::entry_t     push_entry;
  qts_pkg::entry_t     pop_entry;
  logic                push;
  logic                pop;

  qts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_end_of_input (in_end_of_input),
    .fifo_stat       (fifo_stat),
    .push            (push),
    .push_entry      (push_entry)
  );

  qts_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .stat       (fifo_stat)
  );

  qts_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_stat        (fifo_stat),
    .pop_entry        (pop_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_byte   (out_token_byte),
    .out_token_end    (out_token_end),
    .out_token_length (out_token_length),
    .out_terminator   (out_terminator)
  );

endmodule

FILE: sim/tb.sv
// Self-checking bench for quoted_token_scanner_core: drives text words, predicts token words.
// Depends on qts_pkg and the scanner RTL; nothing else.
module tb;

  localparam int RANDOM_WORDS = 400;
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 100000;

  // Receiver stall styles
  localparam int STALL_NONE  = 0;
  localparam int STALL_PULSE = 1;
  localparam int STALL_LIGHT = 2;
  localparam int STALL_HEAVY = 3;

  localparam logic [7:0] DELIMS [13] = '{qts_pkg::CH_LT, qts_pkg::CH_GT,
    qts_pkg::CH_NUL, qts_pkg::CH_COLON, qts_pkg::CH_SEMI, qts_pkg::CH_COMMA,
    qts_pkg::CH_EQUAL, qts_pkg::CH_LBRACE, qts_pkg::CH_RBRACE, qts_pkg::CH_LPAREN,
    qts_pkg::CH_RPAREN, qts_pkg::CH_LBRACK, qts_pkg::CH_RBRACK};
  localparam logic [7:0] SPACERS [4] = '{qts_pkg::CH_SPACE, qts_pkg::CH_TAB,
    qts_pkg::CH_CR, qts_pkg::CH_LF};

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } text_word_t;

  typedef struct packed {
    logic [7:0]  tok_byte;
    logic        tok_end;
    logic [15:0] tok_len;
    logic [7:0]  term;
  } token_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_token_byte;
  logic        out_token_end;
  logic [15:0] out_token_length;
  logic [7:0]  out_terminator;

  // Pending text words and predicted token words
  text_word_t  text_q[$];
  token_word_t due_words[$];

  // Predictor state
  qts_pkg::mode_t sc_mode = qts_pkg::MODE_TOKEN;
  logic        sc_dq = 1'b0;
  logic [15:0] sc_len = '0;

  int          words_total = 0;
  int          words_in = 0;
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_cnt = 0;
  int          stall_style = STALL_NONE;
  logic        in_moved = 1'b0;
  text_word_t  cur;
  token_word_t got;
  token_word_t want;

  quoted_token_scanner_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_byte   (out_token_byte),
    .out_token_end    (out_token_end),
    .out_token_length (out_token_length),
    .out_terminator   (out_terminator)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic qts_pkg::class_t byte_class(input logic [7:0] b);
    qts_pkg::class_t c;
    c = qts_pkg::CL_NORMAL;
    case (b)
      qts_pkg::CH_SQUOTE, qts_pkg::CH_DQUOTE: c = qts_pkg::CL_QUOTE;
      qts_pkg::CH_SPACE, qts_pkg::CH_TAB, qts_pkg::CH_CR,
      qts_pkg::CH_LF: c = qts_pkg::CL_SPACER;
      qts_pkg::CH_LT, qts_pkg::CH_GT, qts_pkg::CH_NUL, qts_pkg::CH_COLON,
      qts_pkg::CH_SEMI, qts_pkg::CH_COMMA, qts_pkg::CH_EQUAL,
      qts_pkg::CH_LBRACE, qts_pkg::CH_RBRACE, qts_pkg::CH_LPAREN,
      qts_pkg::CH_RPAREN, qts_pkg::CH_LBRACK,
      qts_pkg::CH_RBRACK: c = qts_pkg::CL_DELIM;
      default: c = qts_pkg::CL_NORMAL;
    endcase
    return c;
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    due_words.push_back('{tok_byte: b, tok_end: 1'b0, tok_len: 16'd0, term: 8'd0});
    if (sc_len != qts_pkg::LEN_MAX) sc_len++;
  endtask

  task automatic emit_end(input logic [7:0] t);
    due_words.push_back('{tok_byte: 8'd0, tok_end: 1'b1, tok_len: sc_len, term: t});
    sc_len = '0;
  endtask

  // Byte seen in token mode
  task automatic token_byte_seen(input logic [7:0] b);
    case (byte_class(b))
      qts_pkg::CL_QUOTE: begin
        sc_dq = (b == qts_pkg::CH_DQUOTE);
        sc_mode = qts_pkg::MODE_QUOTE;
      end
      qts_pkg::CL_SPACER: begin
        if (sc_len != 0) begin
          emit_end(b);
          sc_mode = qts_pkg::MODE_TAIL;
        end
      end
      qts_pkg::CL_DELIM: begin
        emit_end(b);
        sc_mode = qts_pkg::MODE_TOKEN;
      end
      default: emit_byte(b);
    endcase
  endtask

  task automatic scan_word(input logic [7:0] b, input logic eoi);
    logic [7:0]      q;
    qts_pkg::class_t c;
    q = sc_dq ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE;
    if (eoi) begin
      if (sc_mode != qts_pkg::MODE_TAIL && sc_len != 0) emit_end(qts_pkg::CH_NUL);
      sc_mode = qts_pkg::MODE_TOKEN;
      sc_len = '0;
    end else begin
      case (sc_mode)
        qts_pkg::MODE_QUOTE: begin
          if (b == q) begin
            sc_mode = qts_pkg::MODE_QEND;
          end else if (b == qts_pkg::CH_LF) begin
            emit_byte(qts_pkg::CH_CR);
            emit_byte(qts_pkg::CH_LF);
          end else if (b != qts_pkg::CH_CR) begin
            emit_byte(b);
          end
        end
        qts_pkg::MODE_QEND: begin
          if (b == q) begin
            emit_byte(b);
            sc_mode = qts_pkg::MODE_QUOTE;
          end else begin
            sc_mode = qts_pkg::MODE_TOKEN;
            token_byte_seen(b);
          end
        end
        qts_pkg::MODE_TAIL: begin
          c = byte_class(b);
          if (c != qts_pkg::CL_SPACER) begin
            sc_mode = qts_pkg::MODE_TOKEN;
            if (c != qts_pkg::CL_DELIM) token_byte_seen(b);
          end
        end
        default: begin
          sc_mode = qts_pkg::MODE_TOKEN;
          token_byte_seen(b);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic push_word(input logic [7:0] b, input logic eoi);
    text_q.push_back('{b: b, eoi: eoi});
    words_total++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
  endtask

  function automatic logic [7:0] any_normal();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (byte_class(b) != qts_pkg::CL_NORMAL) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Quoted string with random body, optionally left unclosed
  task automatic push_quoted();
    logic [7:0] q;
    logic [7:0] b;
    int         n;
    q = $urandom_range(0, 1) ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE;
    n = $urandom_range(0, 6);
    push_word(q, 1'b0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: begin
          push_word(q, 1'b0);
          push_word(q, 1'b0);
        end
        1: push_word(qts_pkg::CH_CR, 1'b0);
        2: push_word(qts_pkg::CH_LF, 1'b0);
        3: push_word((q == qts_pkg::CH_DQUOTE) ? qts_pkg::CH_SQUOTE
                                               : qts_pkg::CH_DQUOTE, 1'b0);
        4: push_word(SPACERS[$urandom_range(0, 3)], 1'b0);
        5: push_word(DELIMS[$urandom_range(0, 12)], 1'b0);
        default: begin
          b = 8'($urandom_range(0, 255));
          if (b == q) b = any_normal();
          push_word(b, 1'b0);
        end
      endcase
    end
    if ($urandom_range(0, 9) != 0) push_word(q, 1'b0);
  endtask

  initial begin
    int r;
    int n;
    int stop_at;

    // Directed: leading spacer, extreme byte, spacer end, swallowed delimiter, empty token
    push_str(" ");
    push_word(8'hFF, 1'b0);
    push_str("a \t=[");
    // Doubled quote, other quote, CR dropped, LF expanded, token continues after quotes
    push_word(qts_pkg::CH_DQUOTE, 1'b0);
    push_word(qts_pkg::CH_SQUOTE, 1'b0);
    push_word(qts_pkg::CH_DQUOTE, 1'b0);
    push_word(qts_pkg::CH_DQUOTE, 1'b0);
    push_word(qts_pkg::CH_CR, 1'b0);
    push_word(qts_pkg::CH_LF, 1'b0);
    push_word(qts_pkg::CH_DQUOTE, 1'b0);
    push_str("z''");
    push_word(qts_pkg::CH_NUL, 1'b0);
    // Empty quotes then spacer and end of input: nothing comes out
    push_str("\"\" ");
    push_word(8'h00, 1'b1);
    // Quoted part inside a token, token closed by end of input
    push_str("q'k'");
    push_word(8'hFF, 1'b1);
    // Normal byte after the spacer tail starts the next token
    push_str("m n");
    push_word(8'h5A, 1'b1);

    // Random: mostly well-formed text, some noise
    stop_at = words_total + RANDOM_WORDS;
    while (words_total < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_word(any_normal(), 1'b0);
      end else if (r < 55) begin
        push_quoted();
      end else if (r < 75) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) push_word(SPACERS[$urandom_range(0, 3)], 1'b0);
        if ($urandom_range(0, 1)) push_word(DELIMS[$urandom_range(0, 12)], 1'b0);
      end else if (r < 85) begin
        push_word(DELIMS[$urandom_range(0, 12)], 1'b0);
      end else if (r < 90) begin
        push_word(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end

    // Close whatever token is left open
    push_word(8'h00, 1'b1);

    // Reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain
    while (!(words_in == words_total && due_words.size() == 0)) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && due_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  // Sender: bursts of random length with random gaps; a stalled word holds
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_moved)) begin
      if (gap_left > 0 || text_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        cur = text_q.pop_front();
        in_text_byte <= cur.b;
        in_end_of_input <= cur.eoi;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver stall pattern, style redrawn at random from time to time by stall_cnt
  always @(negedge clk) begin
    if (rst_n) begin
      stall_cnt++;
      if (stall_cnt % 48 == 0) stall_style = $urandom_range(STALL_NONE, STALL_HEAVY);
      case (stall_style)
        STALL_PULSE: out_stall <= stall_cnt[1];
        STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_moved = 1'b0;
    end else begin
      in_moved = in_valid && !in_stall;
      if (in_moved) begin
        scan_word(in_text_byte, in_end_of_input);
        words_in++;
      end
      if (out_valid && !out_stall) begin
        got = '{tok_byte: out_token_byte, tok_end: out_token_end,
                tok_len: out_token_length, term: out_terminator};
        if (due_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected token word, exp none, got byte=%h end=%b len=%0d term=%h",
                   $time, got.tok_byte, got.tok_end, got.tok_len, got.term);
        end else begin
          want = due_words.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: token word mismatch exp byte=%h end=%b len=%0d term=%h,",
                     $time, want.tok_byte, want.tok_end, want.tok_len, want.term);
            $display("%0t:   got byte=%h end=%b len=%0d term=%h",
                     $time, got.tok_byte, got.tok_end, got.tok_len, got.term);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d words in, %0d token words pending",
               $time, words_in, words_total, due_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
